// ===== rtl/core/dual_threshold_strike_velocity_unit_macros.svh =====
// Assertion macros shared by the strike velocity unit.
`ifndef DUAL_THRESHOLD_STRIKE_VELOCITY_UNIT_MACROS_SVH
`define DUAL_THRESHOLD_STRIKE_VELOCITY_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DTSV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DTSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dtsv_pkg.sv =====
// Types, codes and constants of the strike velocity unit.
`default_nettype none

package dtsv_pkg;

  localparam int RB_DEF  = 10;
  localparam int TB_DEF  = 24;
  localparam int NOW_W   = 32;
  localparam int QUIET_W = 24;
  localparam int CMD_W   = 3;
  localparam int QUO_W   = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [QUO_W-1:0] VEL_MAX = 7'd127;

  // Register values after reset, per sensor half.
  localparam int RST_FIRST_THR  = 600;
  localparam int RST_SECOND_THR = 300;
  localparam int RST_SLOW_LIM   = 100000;
  localparam int RST_FAST_LIM   = 2000;
  localparam int RST_QUIET      = 50000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_THR  = 3'd0,
    CFG_SECOND_THR = 3'd1,
    CFG_SLOW_LIM   = 3'd2,
    CFG_FAST_LIM   = 3'd3,
    CFG_QUIET      = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE    = 3'd0,
    CMD_STRIKE  = 3'd1,
    CMD_HOLD    = 3'd2,
    CMD_DONE    = 3'd3,
    CMD_RELEASE = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_ARMED    = 3'd1,
    PH_STRUCK   = 3'd2,
    PH_HELD     = 3'd3,
    PH_RELEASED = 3'd4,
    PH_QUIET    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EVAL,
    SQ_CLAMP,
    SQ_PREP,
    SQ_DIV,
    SQ_PUSH
  } seq_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/dual_threshold_strike_velocity_unit.sv =====
// Top level of the dual-threshold strike velocity unit.
//
//   Channel  Direction  Handshake          Payload
//   in       input      in_valid/in_ready  in_opcode, in_sensor_select, in_reading, in_now_us
//   out      output     out_valid/out_ready out_command, out_velocity, out_sensor_enable,
//                                          out_active_sensor
//   cfg      input      cfg_we             cfg_index, cfg_wdata
//
// A store item produces nothing; store items can stream every cycle while the sequencer
// is idle. An evaluate item passes the evaluate and push steps; one that captures a strike
// also passes the clamp and prep steps and, unless the limits are equal, waits on the
// shared restoring divider, which resolves one quotient bit per cycle (seven) for the velocity.
// A finished result sits in the output register, which frees the sequencer; a second
// result waits in the push step until that register is taken.
// Reset is synchronous and active low; it restores all but the working and payload registers; no clear pass.
`default_nettype none

module dual_threshold_strike_velocity_unit import dtsv_pkg::*; #(
  parameter int READING_BITS = RB_DEF,
  parameter int TIME_BITS    = TB_DEF,
  localparam int CFG_W = ((2 * TIME_BITS > 2 * READING_BITS) ?
                          ((2 * TIME_BITS > QUIET_W) ? 2 * TIME_BITS : QUIET_W) :
                          ((2 * READING_BITS > QUIET_W) ? 2 * READING_BITS : QUIET_W))
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_opcode,
  input  logic                    in_sensor_select,
  input  logic [READING_BITS-1:0] in_reading,
  input  logic [NOW_W-1:0]        in_now_us,
  // Result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CMD_W-1:0]        out_command,
  output logic [QUO_W-1:0]        out_velocity,
  output logic [1:0]              out_sensor_enable,
  output logic                    out_active_sensor,
  // Configuration port
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  localparam int RB    = READING_BITS;
  localparam int TB    = TIME_BITS;
  localparam int NUM_W = TIME_BITS + QUO_W;

  // Configuration registers. Each but quiet_r holds two sensor halves, sensor 0 in the low half.
  logic [2*RB-1:0]    first_thr_r;
  logic [2*RB-1:0]    second_thr_r;
  logic [2*TB-1:0]    slow_lim_r;
  logic [2*TB-1:0]    fast_lim_r;
  logic [QUIET_W-1:0] quiet_r;

  // Strike state.
  logic [RB-1:0]    rd_r [2];
  phase_t           phase_r, phase_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [QUO_W-1:0] vel_r, vel_nxt;
  logic [1:0]       enable_r, enable_nxt;
  logic             armed_r, armed_nxt;
  logic [NOW_W-1:0] start_r, start_nxt;

  // Sequencer and working registers of one evaluate item.
  seq_t             sq_r, sq_nxt;
  logic [NOW_W-1:0] now_r;
  logic [NOW_W-1:0] elapsed_r, elapsed_nxt;
  logic [TB-1:0]    t_r, t_nxt;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [CMD_W-1:0] out_command_r;
  logic [QUO_W-1:0] out_velocity_r;
  logic [1:0]       out_enable_r;
  logic             out_active_r;

  // Sequencer outputs.
  logic in_take;
  logic div_start;
  logic out_load;

  // Selected per-sensor values for the armed sensor.
  logic [RB-1:0]    rd_s;
  logic [RB-1:0]    first_s;
  logic [RB-1:0]    second_s;
  logic [TB-1:0]    slow_s;
  logic [TB-1:0]    fast_s;
  logic             strike_hit;
  logic             lim_equal;
  logic [TB-1:0]    diff;
  logic [TB-1:0]    den;
  logic [NUM_W-1:0] num;

  div_sts_t         div_sts;
  logic [QUO_W-1:0] div_quo;

  assign rd_s     = armed_r ? rd_r[1] : rd_r[0];
  assign first_s  = armed_r ? first_thr_r[2*RB-1:RB]  : first_thr_r[RB-1:0];
  assign second_s = armed_r ? second_thr_r[2*RB-1:RB] : second_thr_r[RB-1:0];
  assign slow_s   = armed_r ? slow_lim_r[2*TB-1:TB]   : slow_lim_r[TB-1:0];
  assign fast_s   = armed_r ? fast_lim_r[2*TB-1:TB]   : fast_lim_r[TB-1:0];

  // An armed sensor that has passed its strike threshold captures a velocity.
  assign strike_hit = (phase_r == PH_ARMED) && (rd_s < second_s);
  assign lim_equal  = (fast_s == slow_s);

  // The clamped time always sits between the two limits, so the distance from the
  // slow limit and the span are both non-negative once taken in the right order.
  // With the limits crossed the clamp lands on one of the limits and gives 127 or 1.
  always_comb begin
    if (fast_s < slow_s) begin
      diff = slow_s - t_r;
      den  = slow_s - fast_s;
    end else begin
      diff = t_r - slow_s;
      den  = fast_s - slow_s;
    end
    num = NUM_W'(diff) * NUM_W'(VEL_MAX - QUO_W'(1));
  end

  dtsv_divider #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  // Sequencer: next state.
  always_comb begin
    sq_nxt = sq_r;
    unique case (sq_r)
      SQ_IDLE: begin
        if (in_valid && (in_opcode == OP_EVAL)) begin
          sq_nxt = SQ_EVAL;
        end
      end
      SQ_EVAL: begin
        sq_nxt = strike_hit ? SQ_CLAMP : SQ_PUSH;
      end
      SQ_CLAMP: begin
        sq_nxt = SQ_PREP;
      end
      SQ_PREP: begin
        sq_nxt = lim_equal ? SQ_PUSH : SQ_DIV;
      end
      SQ_DIV: begin
        if (div_sts.done) begin
          sq_nxt = SQ_PUSH;
        end
      end
      SQ_PUSH: begin
        if (!out_valid_r || out_ready) begin
          sq_nxt = SQ_IDLE;
        end
      end
      default: begin
        sq_nxt = SQ_IDLE;
      end
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_take   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (sq_r)
      SQ_IDLE: begin
        in_take = 1'b1;
      end
      SQ_PREP: begin
        div_start = !lim_equal;
      end
      SQ_PUSH: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_take = 1'b0;
      end
    endcase
  end

  assign in_ready = in_take;

  // Strike state machine, one step per evaluate item, plus the velocity capture.
  always_comb begin
    phase_nxt   = phase_r;
    cmd_nxt     = cmd_r;
    vel_nxt     = vel_r;
    enable_nxt  = enable_r;
    armed_nxt   = armed_r;
    start_nxt   = start_r;
    elapsed_nxt = elapsed_r;
    t_nxt       = t_r;

    if (sq_r == SQ_EVAL) begin
      unique case (phase_r)
        PH_IDLE: begin
          // Sensor 0 wins when both are past the arming threshold.
          if (rd_r[0] < first_thr_r[RB-1:0]) begin
            enable_nxt = 2'b01;
            start_nxt  = now_r;
            phase_nxt  = PH_ARMED;
            armed_nxt  = 1'b0;
          end else if (rd_r[1] < first_thr_r[2*RB-1:RB]) begin
            enable_nxt = 2'b10;
            start_nxt  = now_r;
            phase_nxt  = PH_ARMED;
            armed_nxt  = 1'b1;
          end
        end
        PH_ARMED: begin
          if (strike_hit) begin
            elapsed_nxt = now_r - start_r;
            phase_nxt   = PH_STRUCK;
            cmd_nxt     = CMD_STRIKE;
          end else if (rd_s > first_s) begin
            phase_nxt  = PH_IDLE;
            enable_nxt = 2'b11;
          end
        end
        PH_STRUCK: begin
          phase_nxt = PH_HELD;
          cmd_nxt   = CMD_HOLD;
        end
        PH_HELD: begin
          if (rd_s > first_s) begin
            cmd_nxt    = CMD_RELEASE;
            phase_nxt  = PH_RELEASED;
            enable_nxt = 2'b00;
            start_nxt  = now_r;
          end
        end
        PH_RELEASED: begin
          cmd_nxt   = CMD_DONE;
          phase_nxt = PH_QUIET;
        end
        PH_QUIET: begin
          if ((now_r - start_r) > NOW_W'(quiet_r)) begin
            phase_nxt  = PH_IDLE;
            enable_nxt = 2'b11;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    // Clamp the travel time: the fast limit is tested first.
    if (sq_r == SQ_CLAMP) begin
      if (elapsed_r < NOW_W'(fast_s)) begin
        t_nxt = fast_s;
      end else if (elapsed_r > NOW_W'(slow_s)) begin
        t_nxt = slow_s;
      end else begin
        t_nxt = elapsed_r[TB-1:0];
      end
    end

    if ((sq_r == SQ_PREP) && lim_equal) begin
      vel_nxt = VEL_MAX;
    end

    if ((sq_r == SQ_DIV) && div_sts.done) begin
      vel_nxt = div_quo + QUO_W'(1);
    end
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_thr_r  <= {RB'(RST_FIRST_THR), RB'(RST_FIRST_THR)};
      second_thr_r <= {RB'(RST_SECOND_THR), RB'(RST_SECOND_THR)};
      slow_lim_r   <= {TB'(RST_SLOW_LIM), TB'(RST_SLOW_LIM)};
      fast_lim_r   <= {TB'(RST_FAST_LIM), TB'(RST_FAST_LIM)};
      quiet_r      <= QUIET_W'(RST_QUIET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_THR:  first_thr_r  <= cfg_wdata[2*RB-1:0];
        CFG_SECOND_THR: second_thr_r <= cfg_wdata[2*RB-1:0];
        CFG_SLOW_LIM:   slow_lim_r   <= cfg_wdata[2*TB-1:0];
        CFG_FAST_LIM:   fast_lim_r   <= cfg_wdata[2*TB-1:0];
        CFG_QUIET:      quiet_r      <= cfg_wdata[QUIET_W-1:0];
        default:        quiet_r      <= quiet_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r[0]     <= '1;
      rd_r[1]     <= '1;
      phase_r     <= PH_IDLE;
      cmd_r       <= CMD_NONE;
      vel_r       <= '0;
      enable_r    <= 2'b11;
      armed_r     <= 1'b0;
      start_r     <= '0;
      sq_r        <= SQ_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready && (in_opcode == OP_STORE)) begin
        rd_r[in_sensor_select] <= in_reading;
      end
      phase_r     <= phase_nxt;
      cmd_r       <= cmd_nxt;
      vel_r       <= vel_nxt;
      enable_r    <= enable_nxt;
      armed_r     <= armed_nxt;
      start_r     <= start_nxt;
      sq_r        <= sq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r <= in_now_us;
    end
    elapsed_r <= elapsed_nxt;
    t_r       <= t_nxt;
    if (out_load) begin
      out_command_r  <= cmd_r;
      out_velocity_r <= vel_r;
      out_enable_r   <= enable_r;
      out_active_r   <= armed_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_command       = out_command_r;
  assign out_velocity      = out_velocity_r;
  assign out_sensor_enable = out_enable_r;
  assign out_active_sensor = out_active_r;

  `include "dual_threshold_strike_velocity_unit_macros.svh"

  // The divider only runs while the sequencer waits on it, and the block takes no item then.
  `DTSV_ASSERT_NOW(a_div_blocks_input, div_sts.busy, (sq_r == SQ_DIV) && !in_ready, "divider busy outside wait step")
  // A quotient is only produced for a strike being captured.
  `DTSV_ASSERT_NOW(a_done_in_div, div_sts.done, (sq_r == SQ_DIV) && (phase_r == PH_STRUCK), "divider done out of sequence")
  // While armed, exactly the arming sensor is enabled.
  `DTSV_ASSERT_NOW(a_armed_onehot, phase_r == PH_ARMED, $onehot(enable_r) && enable_r[armed_r], "armed with bad enables")
  // Loading the output register frees the sequencer for the next item.
  `DTSV_ASSERT_NEXT(a_load_frees, out_load, in_ready && out_valid_r, "sequencer not freed after load")

endmodule

`default_nettype wire

// ===== rtl/core/dtsv_divider.sv =====
// Restoring divider that produces the 7-bit velocity quotient, one bit a cycle.
`default_nettype none

module dtsv_divider import dtsv_pkg::*; #(
  parameter int TIME_BITS = TB_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [TIME_BITS+QUO_W-1:0]     num,
  input  logic [TIME_BITS-1:0]           den,
  output div_sts_t                       sts,
  output logic [QUO_W-1:0]               quo
);

  localparam int NUM_W = TIME_BITS + QUO_W;
  localparam int CNT_W = $clog2(QUO_W);

  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] dsh_r, dsh_nxt;
  logic [QUO_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             fits;

  assign fits = (rem_r >= dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = NUM_W'(den) << (QUO_W - 1);
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // One quotient bit per cycle, divisor walks down one place.
      if (fits) begin
        rem_nxt = rem_r - dsh_r;
      end
      q_nxt   = {q_r[QUO_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      if (cnt_r == CNT_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = q_r;

endmodule

`default_nettype wire

// ===== tb/sv/tb_dual_threshold_strike_velocity_unit.sv =====
// Self-checking testbench for the dual-threshold strike velocity unit.
`default_nettype none

module tb_dual_threshold_strike_velocity_unit;
  import dtsv_pkg::*;

  localparam int RD_W             = RB_DEF;
  localparam int TM_W             = TB_DEF;
  localparam int CFG_DW           = 2 * TM_W;
  localparam longint VEL_TOP      = longint'(VEL_MAX);
  // Margin that covers a strike evaluation and its push step.
  localparam int DRAIN_CYCLES     = 24;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE  = 135;
  localparam logic [RD_W-1:0] LEVEL_RELEASED = '1;

  // One expected output item of the unit.
  typedef struct {
    cmd_t               command;
    logic [QUO_W-1:0]   velocity;
    logic [1:0]         enables;
    logic               sensor;
  } strike_report_t;

  // Tracks the strike machine, predicts the report of every evaluate item and
  // compares the reports that the unit delivers against those predictions.
  class strike_checker;
    logic [2*RD_W-1:0]  arm_thr;
    logic [2*RD_W-1:0]  hit_thr;
    logic [2*TM_W-1:0]  slow_lim;
    logic [2*TM_W-1:0]  fast_lim;
    logic [QUIET_W-1:0] quiet_us;
    logic [RD_W-1:0]    level [2];
    phase_t             ph;
    cmd_t               cmd;
    logic [QUO_W-1:0]   vel;
    logic [1:0]         enables;
    logic               armed;
    logic [NOW_W-1:0]   t_start;
    strike_report_t     pending_reports [$];
    int                 errors;

    function new();
      arm_thr  = {RD_W'(RST_FIRST_THR), RD_W'(RST_FIRST_THR)};
      hit_thr  = {RD_W'(RST_SECOND_THR), RD_W'(RST_SECOND_THR)};
      slow_lim = {TM_W'(RST_SLOW_LIM), TM_W'(RST_SLOW_LIM)};
      fast_lim = {TM_W'(RST_FAST_LIM), TM_W'(RST_FAST_LIM)};
      quiet_us = QUIET_W'(RST_QUIET);
      level[0] = LEVEL_RELEASED;
      level[1] = LEVEL_RELEASED;
      ph       = PH_IDLE;
      cmd      = CMD_NONE;
      vel      = '0;
      enables  = 2'b11;
      armed    = 1'b0;
      t_start  = '0;
      errors   = 0;
    endfunction

    function logic [RD_W-1:0] arm_level(logic s);
      return s ? arm_thr[2*RD_W-1:RD_W] : arm_thr[RD_W-1:0];
    endfunction

    function logic [RD_W-1:0] hit_level(logic s);
      return s ? hit_thr[2*RD_W-1:RD_W] : hit_thr[RD_W-1:0];
    endfunction

    function logic [TM_W-1:0] slow_of(logic s);
      return s ? slow_lim[2*TM_W-1:TM_W] : slow_lim[TM_W-1:0];
    endfunction

    function logic [TM_W-1:0] fast_of(logic s);
      return s ? fast_lim[2*TM_W-1:TM_W] : fast_lim[TM_W-1:0];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        CFG_FIRST_THR:  arm_thr  = data[2*RD_W-1:0];
        CFG_SECOND_THR: hit_thr  = data[2*RD_W-1:0];
        CFG_SLOW_LIM:   slow_lim = data[2*TM_W-1:0];
        CFG_FAST_LIM:   fast_lim = data[2*TM_W-1:0];
        CFG_QUIET:      quiet_us = data[QUIET_W-1:0];
        default: ;
      endcase
    endfunction

    // Clamp the travel time to the sensor's limits, fast limit first, and map it
    // linearly onto 1..127 with truncation toward zero.
    function logic [QUO_W-1:0] travel_to_velocity(logic [NOW_W-1:0] elapsed, logic s);
      longint slowest;
      longint fastest;
      longint t;
      longint span;
      slowest = longint'(slow_of(s));
      fastest = longint'(fast_of(s));
      t       = longint'(elapsed);
      if (t < fastest) t = fastest;
      else if (t > slowest) t = slowest;
      span = fastest - slowest;
      if (span == 0) return VEL_MAX;
      return QUO_W'((t - slowest) * (VEL_TOP - 1) / span + 1);
    endfunction

    function void note_input(op_t op, logic sel, logic [RD_W-1:0] rd, logic [NOW_W-1:0] now);
      logic             s;
      logic [NOW_W-1:0] since;
      strike_report_t   rep;
      s     = armed;
      since = now - t_start;
      if (op == OP_STORE) begin
        level[sel] = rd;
        return;
      end
      case (ph)
        PH_IDLE: begin
          // Sensor 0 is looked at first, so it wins when both are low.
          if (level[0] < arm_level(1'b0)) begin
            enables = 2'b01;
            t_start = now;
            ph      = PH_ARMED;
            armed   = 1'b0;
          end else if (level[1] < arm_level(1'b1)) begin
            enables = 2'b10;
            t_start = now;
            ph      = PH_ARMED;
            armed   = 1'b1;
          end
        end
        PH_ARMED: begin
          if (level[s] < hit_level(s)) begin
            vel = travel_to_velocity(since, s);
            ph  = PH_STRUCK;
            cmd = CMD_STRIKE;
          end else if (level[s] > arm_level(s)) begin
            ph      = PH_IDLE;
            enables = 2'b11;
          end
        end
        PH_STRUCK: begin
          ph  = PH_HELD;
          cmd = CMD_HOLD;
        end
        PH_HELD: begin
          if (level[s] > arm_level(s)) begin
            cmd     = CMD_RELEASE;
            ph      = PH_RELEASED;
            enables = 2'b00;
            t_start = now;
          end
        end
        PH_RELEASED: begin
          cmd = CMD_DONE;
          ph  = PH_QUIET;
        end
        PH_QUIET: begin
          if (since > NOW_W'(quiet_us)) begin
            ph      = PH_IDLE;
            enables = 2'b11;
          end
        end
        default: ;
      endcase
      rep.command  = cmd;
      rep.velocity = vel;
      rep.enables  = enables;
      rep.sensor   = armed;
      pending_reports.push_back(rep);
    endfunction

    function void check_result(logic [CMD_W-1:0] c, logic [QUO_W-1:0] v, logic [1:0] e,
                               logic a);
      strike_report_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report: command %0d velocity %0d enables %0d sensor %0d",
                 $time, c, v, e, a);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      if (c !== want.command) begin
        $display("%0t: command: expected %0d, got %0d", $time, want.command, c);
        errors++;
      end
      if (v !== want.velocity) begin
        $display("%0t: velocity: expected %0d, got %0d", $time, want.velocity, v);
        errors++;
      end
      if (e !== want.enables) begin
        $display("%0t: sensor_enable: expected %0d, got %0d", $time, want.enables, e);
        errors++;
      end
      if (a !== want.sensor) begin
        $display("%0t: active_sensor: expected %0d, got %0d", $time, want.sensor, a);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n            = 1'b0;
  logic                 in_valid         = 1'b0;
  logic                 in_ready;
  logic                 in_opcode        = 1'b0;
  logic                 in_sensor_select = 1'b0;
  logic [RD_W-1:0]      in_reading       = '0;
  logic [NOW_W-1:0]     in_now_us        = '0;
  logic                 out_valid;
  logic                 out_ready        = 1'b0;
  logic [CMD_W-1:0]     out_command;
  logic [QUO_W-1:0]     out_velocity;
  logic [1:0]           out_sensor_enable;
  logic                 out_active_sensor;
  logic                 cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [CFG_DW-1:0]    cfg_wdata        = '0;

  strike_checker        tracker          = new();
  int                   burst_left       = 0;
  bit                   hold_req         = 1'b0;
  // Timestamp of the latest evaluate item; most new timestamps step forward from it.
  logic [NOW_W-1:0]     clock_us         = '0;

  dual_threshold_strike_velocity_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_sensor_select  (in_sensor_select),
    .in_reading        (in_reading),
    .in_now_us         (in_now_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_command       (out_command),
    .out_velocity      (out_velocity),
    .out_sensor_enable (out_sensor_enable),
    .out_active_sensor (out_active_sensor),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run; a hang anywhere ends up here.
  initial begin
    #2000000;
    $display("** dual_threshold_strike_velocity_unit: FAILED **");
    $finish;
  end

  // Every report the unit hands over is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_result(out_command, out_velocity, out_sensor_enable, out_active_sensor);
    end
  end

  // Result side: mostly short stalls, a few long ones, and stretches of steady
  // acceptance. On request it holds off for a long count of cycles so that the
  // unit fills up and pushes back on its input.
  initial begin
    int roll;
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        out_ready <= 1'b1;
        if (roll < 10) repeat ($urandom_range(30, 100)) @(posedge clk);
        else repeat ($urandom_range(1, 4)) @(posedge clk);
        roll = $urandom_range(0, 99);
        if (roll < 40) stall = 0;
        else if (roll < 90) stall = $urandom_range(1, 3);
        else if (roll < 98) stall = $urandom_range(4, 15);
        else stall = $urandom_range(20, 60);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Input side gap after each accepted item. Bursts give stretches with no gaps.
  task automatic pause_sender();
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if (roll < 2) begin
      burst_left = $urandom_range(20, 60);
      gap = 0;
    end else if (roll < 55) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else if (roll < 98) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 50);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offers one item and holds it until the unit takes it.
  task automatic send_item(op_t op, logic sel, logic [RD_W-1:0] rd, logic [NOW_W-1:0] now);
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_sensor_select <= sel;
    in_reading       <= rd;
    in_now_us        <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_input(op, sel, rd, now);
    pause_sender();
  endtask

  // Store items carry a random timestamp, which the unit must ignore.
  task automatic store_level(logic sel, logic [RD_W-1:0] rd);
    send_item(OP_STORE, sel, rd, $urandom);
  endtask

  // Evaluate items carry random sensor and reading fields, which the unit must ignore.
  task automatic evaluate_at(logic [NOW_W-1:0] now);
    clock_us = now;
    send_item(OP_EVAL, 1'($urandom), RD_W'($urandom), now);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  // Writes all five registers, then the unused indexes with junk that must be dropped.
  task automatic program_regs(logic [CFG_DW-1:0] first, logic [CFG_DW-1:0] second,
                              logic [CFG_DW-1:0] slow, logic [CFG_DW-1:0] fast,
                              logic [CFG_DW-1:0] quiet);
    cfg_write(CFG_FIRST_THR, first);
    cfg_write(CFG_SECOND_THR, second);
    cfg_write(CFG_SLOW_LIM, slow);
    cfg_write(CFG_FAST_LIM, fast);
    cfg_write(CFG_QUIET, quiet);
    for (int k = int'(CFG_QUIET) + 1; k < (1 << CFG_IDX_W); k++) begin
      cfg_write(CFG_IDX_W'(k), CFG_DW'({$urandom, $urandom}));
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering items and waits until every predicted report has arrived and
  // the unit has had time to finish any work that produces no report.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Threshold words keep random junk above the two packed readings.
  function automatic logic [CFG_DW-1:0] thr_pair(logic [RD_W-1:0] s0, logic [RD_W-1:0] s1);
    logic [CFG_DW-1:0] word;
    word = CFG_DW'({$urandom, $urandom});
    word[2*RD_W-1:0] = {s1, s0};
    return word;
  endfunction

  function automatic logic [CFG_DW-1:0] quiet_word(logic [QUIET_W-1:0] q);
    logic [CFG_DW-1:0] word;
    word = CFG_DW'({$urandom, $urandom});
    word[QUIET_W-1:0] = q;
    return word;
  endfunction

  function automatic logic [RD_W-1:0] level_below(logic [RD_W-1:0] lim);
    return RD_W'($urandom_range(0, int'(lim) - 1));
  endfunction

  function automatic logic [RD_W-1:0] level_above(logic [RD_W-1:0] lim);
    return RD_W'($urandom_range(int'(lim) + 1, int'(LEVEL_RELEASED)));
  endfunction

  // Travel time for a strike: limits, one past them, anything between, or any value.
  function automatic logic [NOW_W-1:0] pick_travel(logic s);
    logic [NOW_W-1:0] f;
    logic [NOW_W-1:0] sl;
    f  = NOW_W'(tracker.fast_of(s));
    sl = NOW_W'(tracker.slow_of(s));
    case ($urandom_range(0, 9))
      0: return f;
      1: return sl;
      2: return f - 1;
      3: return sl + 1;
      4: return $urandom;
      default: return $urandom_range(f, sl);
    endcase
  endfunction

  task automatic noise_item();
    if ($urandom_range(0, 1) == 0) store_level(1'($urandom), RD_W'($urandom));
    else if ($urandom_range(0, 3) == 0) evaluate_at($urandom);
    else evaluate_at(clock_us + $urandom_range(0, 5000));
  endtask

  // One item that most of the time moves the strike machine toward its next phase,
  // using the predicted state to choose readings and timestamps that do so.
  task automatic strike_step();
    logic               s;
    logic               pick;
    logic [RD_W-1:0]    arm_s;
    logic [RD_W-1:0]    hit_s;
    logic [QUIET_W-1:0] quiet;
    int                 roll;
    s     = tracker.armed;
    arm_s = tracker.arm_level(s);
    hit_s = tracker.hit_level(s);
    quiet = tracker.quiet_us;
    roll  = $urandom_range(0, 99);
    if (roll < 12) begin
      noise_item();
      return;
    end
    case (tracker.ph)
      PH_IDLE: begin
        pick = 1'($urandom);
        if (tracker.level[0] < tracker.arm_level(1'b0) ||
            tracker.level[1] < tracker.arm_level(1'b1)) begin
          evaluate_at(clock_us + $urandom_range(0, 2000));
        end else if (tracker.arm_level(pick) != '0) begin
          store_level(pick, level_below(tracker.arm_level(pick)));
        end else if (tracker.arm_level(!pick) != '0) begin
          store_level(!pick, level_below(tracker.arm_level(!pick)));
        end else begin
          evaluate_at(clock_us + $urandom_range(0, 2000));
        end
      end
      PH_ARMED: begin
        if (tracker.level[s] < hit_s) evaluate_at(tracker.t_start + pick_travel(s));
        else if (roll < 80 && hit_s != '0) store_level(s, level_below(hit_s));
        else if (roll < 90 && arm_s != LEVEL_RELEASED) store_level(s, level_above(arm_s));
        else evaluate_at(clock_us + $urandom_range(0, 500));
      end
      PH_HELD: begin
        if (tracker.level[s] > arm_s || roll > 85 || arm_s == LEVEL_RELEASED) begin
          evaluate_at(clock_us + $urandom_range(0, 20000));
        end else begin
          store_level(s, level_above(arm_s));
        end
      end
      PH_QUIET: begin
        // Mostly just past the quiet period, sometimes inside it, now and then anywhere.
        if (roll < 70) evaluate_at(tracker.t_start + quiet + 1 + $urandom_range(0, 100));
        else if (roll < 92) evaluate_at(tracker.t_start + $urandom_range(0, int'(quiet)));
        else evaluate_at($urandom);
      end
      default: evaluate_at(clock_us + $urandom_range(0, 3000));
    endcase
  endtask

  // A phase of steered random items. With pressure, the result side is told to hold
  // off while the input side streams items with no gaps.
  task automatic run_random(int n_items, bit pressure);
    for (int i = 0; i < n_items; i++) begin
      if (pressure && i == n_items / 4) begin
        hold_req   = 1'b1;
        burst_left = 80;
      end
      strike_step();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings. First an evaluation with nothing pressed.
    evaluate_at(32'd0);
    // Both sensors pressed: sensor 0 arms, at the top of the timestamp range.
    store_level(1'b0, 10'd0);
    store_level(1'b1, 10'd0);
    evaluate_at(32'hFFFF_FFFF);
    // Sensor 0 comes back up while armed, so the machine disarms.
    store_level(1'b0, LEVEL_RELEASED);
    evaluate_at(32'd5);
    // A reading equal to the arming threshold does not arm; sensor 1 just below does.
    store_level(1'b0, 10'd600);
    store_level(1'b1, 10'd599);
    evaluate_at(32'hFFFF_0000);
    // Between the thresholds nothing changes.
    store_level(1'b1, 10'd300);
    evaluate_at(32'hFFFF_0010);
    // Strike exactly at the fast limit gives full velocity, then hold twice.
    store_level(1'b1, 10'd299);
    evaluate_at(32'hFFFF_0000 + 32'd2000);
    evaluate_at(32'hFFFF_1000);
    evaluate_at(32'hFFFF_2000);
    // Release, then done; the quiet period straddles the timestamp wrap.
    store_level(1'b1, 10'd601);
    evaluate_at(32'hFFFF_FFF0);
    evaluate_at(32'hFFFF_FFF8);
    evaluate_at(32'hFFFF_FFF0 + 32'd50000);
    evaluate_at(32'hFFFF_FFF0 + 32'd50001);
    // Sensor 0 arms and strikes exactly at the slow limit, giving velocity 1.
    store_level(1'b0, 10'd0);
    evaluate_at(32'h7FFF_FFFF);
    evaluate_at(32'h7FFF_FFFF + 32'd100000);
    evaluate_at(32'h8002_0000);
    store_level(1'b0, LEVEL_RELEASED);
    evaluate_at(32'h8003_0000);
    evaluate_at(32'h8003_0001);

    run_random(ITEMS_PER_PHASE, 1'b0);
    drain_results();

    // Ordinary settings with different values per sensor; the long hold-off runs here.
    program_regs(thr_pair(10'd700, 10'd450), thr_pair(10'd200, 10'd100),
                 {24'd9000, 24'd60000}, {24'd1200, 24'd500}, quiet_word(24'd3000));
    run_random(ITEMS_PER_PHASE, 1'b1);
    drain_results();

    // Sensor 0 arms on any reading short of fully released and can never be released;
    // sensor 1 can never arm. Widest possible travel range and no quiet period.
    program_regs(thr_pair(LEVEL_RELEASED, 10'd0), thr_pair(LEVEL_RELEASED, 10'd0),
                 {24'd0, 24'hFF_FFFF}, {24'd0, 24'd0}, quiet_word(24'd0));
    run_random(ITEMS_PER_PHASE, 1'b0);
    drain_results();

    // Equal limits on each sensor, at both ends of the range; longest quiet period.
    program_regs(thr_pair(10'd600, 10'd800), thr_pair(10'd300, 10'd100),
                 {24'hFF_FFFF, 24'd0}, {24'hFF_FFFF, 24'd0}, quiet_word(24'hFF_FFFF));
    run_random(ITEMS_PER_PHASE, 1'b0);
    drain_results();

    // Fast limit above the slow limit on both sensors.
    program_regs(thr_pair(10'd900, 10'd1000), thr_pair(10'd512, 10'd700),
                 {24'd0, 24'd1000}, {24'd5000, 24'd8000}, quiet_word(24'd1));
    run_random(ITEMS_PER_PHASE, 1'b0);
    drain_results();

    // Every register written with all ones.
    program_regs('1, '1, '1, '1, '1);
    run_random(ITEMS_PER_PHASE, 1'b0);
    drain_results();

    // Every register written with zeros: nothing can arm any more.
    program_regs('0, '0, '0, '0, '0);
    run_random(ITEMS_PER_PHASE, 1'b0);
    drain_results();

    // Random settings to finish.
    program_regs(thr_pair(RD_W'($urandom), RD_W'($urandom)),
                 thr_pair(RD_W'($urandom), RD_W'($urandom)),
                 {TM_W'($urandom_range(0, 200000)), TM_W'($urandom_range(0, 200000))},
                 {TM_W'($urandom_range(0, 20000)), TM_W'($urandom_range(0, 20000))},
                 quiet_word(QUIET_W'($urandom_range(0, 65535))));
    run_random(ITEMS_PER_PHASE, 1'b0);
    drain_results();

    if (tracker.errors == 0) begin
      $display("** dual_threshold_strike_velocity_unit: PASSED **");
    end else begin
      $display("** dual_threshold_strike_velocity_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
